[rtl/core/assert_macros.svh]
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FTVD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define FTVD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define FTVD_ASSERT(lbl, clk, rst_n, prop)

`define FTVD_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/core/ftvd_pkg.sv]
`timescale 1ns / 1ps

package ftvd_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int OUT_IDX_W    = 10;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_FRONT  = 2'd1;
	localparam logic [1:0] KIND_BACK   = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [1:0] FAN_EMPTY = 2'd0;
	localparam logic [1:0] FAN_START = 2'd1;
	localparam logic [1:0] FAN_RUN   = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_ANIM   = 2'd1,
		OP_NORMAL = 2'd2
	} op_t;

	typedef struct packed {
		logic        command;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
		logic        animated;
		logic        two_sided;
		logic        first_vertex;
	} in_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [OUT_IDX_W-1:0] index_a;
		logic [OUT_IDX_W-1:0] index_b;
		logic [OUT_IDX_W-1:0] index_c;
		logic                 new_vertex;
		logic                 from_animated;
		logic                 table_full;
		logic                 last;
	} out_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
	} key_t;

	typedef struct packed {
		op_t  op;
		key_t key;
		logic animated;
		logic two_sided;
		logic first_vertex;
	} qent_t;

	// float equality: NaN never matches, +0 == -0
	function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
		logic a_nan;
		logic b_nan;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (a_nan || b_nan) begin
			return 1'b0;
		end
		if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
			return 1'b1;
		end
		return a == b;
	endfunction

	function automatic logic key_eq(input key_t a, input key_t b);
		return feq(a.pos_x, b.pos_x) && feq(a.pos_y, b.pos_y) &&
			feq(a.pos_z, b.pos_z) && feq(a.tex_u, b.tex_u) &&
			feq(a.tex_v, b.tex_v);
	endfunction

	function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] i);
		logic [IDX_W+OUT_IDX_W-1:0] w;
		w = (IDX_W + OUT_IDX_W)'(i);
		return w[OUT_IDX_W-1:0];
	endfunction

endpackage

[rtl/core/ftvd_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftvd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ftvd_pkg::in_t  item,
	output logic           q_vld,
	output ftvd_pkg::qent_t q_head,
	input  logic           pop
);
	import ftvd_pkg::*;

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] q_cnt_q;
	logic              accept;
	qent_t             ent_in;

	assign busy   = (q_cnt_q == QCNT_W'(QDEPTH));
	assign accept = start && !busy;
	assign q_vld  = (q_cnt_q != '0);
	assign q_head = ent_q[rd_ptr_q];

	always_comb begin
		ent_in.key.pos_x  = item.pos_x;
		ent_in.key.pos_y  = item.pos_y;
		ent_in.key.pos_z  = item.pos_z;
		ent_in.key.tex_u  = item.tex_u;
		ent_in.key.tex_v  = item.tex_v;
		ent_in.animated     = item.animated;
		ent_in.two_sided    = item.two_sided;
		ent_in.first_vertex = item.first_vertex;
		priority if (item.command) begin
			ent_in.op = OP_CLEAR;
		end else if (item.animated) begin
			ent_in.op = OP_ANIM;
		end else begin
			ent_in.op = OP_NORMAL;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_ptr_q] <= ent_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			q_cnt_q <= q_cnt_q + QCNT_W'(accept) - QCNT_W'(pop);
		end
	end

	`FTVD_NEVER(a_pop_empty, clk, arst_n, pop && (q_cnt_q == '0))
	`FTVD_NEVER(a_q_over, clk, arst_n, q_cnt_q > QCNT_W'(QDEPTH))
	`FTVD_ASSERT(a_cnt_ptr, clk, arst_n, (q_cnt_q == QCNT_W'(QDEPTH)) || (q_cnt_q == QCNT_W'(QPTR_W'(wr_ptr_q - rd_ptr_q))))

endmodule

[rtl/core/ftvd_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ftvd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_vld,
	input  ftvd_pkg::qent_t q_head,
	output logic            pop,
	output logic            result_valid,
	output ftvd_pkg::out_t  result
);
	import ftvd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DISP   = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_REPORT = 6'b001000,
		ST_FRONT  = 6'b010000,
		ST_BACK   = 6'b100000
	} state_t;

	key_t             key_mem [MAX_VERTICES];
	key_t             rd_key_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_idx_q;

	state_t           state_q;
	qent_t            item_q;
	logic [CNT_W-1:0] normal_cnt_q;
	logic [CNT_W-1:0] anim_cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [IDX_W-1:0] fan_start_q;
	logic [IDX_W-1:0] fan_prev_q;
	logic [1:0]       fan_pos_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             res_nv_q;
	logic             res_full_q;
	logic             out_vld_q;
	out_t             out_q;

	logic             in_scan;
	logic             hit;
	logic             scan_end;
	logic             issue;
	logic             wr_en;
	logic             beat_nxt;

	assign in_scan  = (state_q == ST_SCAN);
	assign hit      = in_scan && rd_vld_q && key_eq(rd_key_q, item_q.key);
	assign issue    = in_scan && !hit && (ptr_q < normal_cnt_q);
	assign scan_end = in_scan && !hit && !rd_vld_q && (ptr_q == normal_cnt_q);
	assign wr_en    = scan_end && (normal_cnt_q < MAX_CNT);
	assign pop      = (state_q == ST_IDLE) && q_vld;
	assign beat_nxt = (state_q == ST_REPORT) || (state_q == ST_FRONT) ||
		(state_q == ST_BACK) || ((state_q == ST_DISP) && (item_q.op == OP_CLEAR));

	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[normal_cnt_q[IDX_W-1:0]] <= item_q.key;
		end
		if (issue) begin
			rd_key_q <= key_mem[ptr_q[IDX_W-1:0]];
			rd_idx_q <= ptr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_q       <= '0;
			normal_cnt_q <= '0;
			anim_cnt_q   <= '0;
			ptr_q        <= '0;
			fan_start_q  <= '0;
			fan_prev_q   <= '0;
			fan_pos_q    <= FAN_EMPTY;
			res_idx_q    <= '0;
			res_nv_q     <= 1'b0;
			res_full_q   <= 1'b0;
			rd_vld_q     <= 1'b0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
		end else begin
			rd_vld_q  <= issue;
			out_vld_q <= beat_nxt;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_vld) begin
						item_q  <= q_head;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					if (item_q.first_vertex && (item_q.op != OP_CLEAR)) begin
						fan_pos_q <= FAN_EMPTY;
					end
					unique case (item_q.op)
						OP_CLEAR: begin
							normal_cnt_q        <= '0;
							anim_cnt_q          <= '0;
							fan_start_q         <= '0;
							fan_prev_q          <= '0;
							fan_pos_q           <= FAN_EMPTY;
							out_q.kind          <= KIND_CLEAR;
							out_q.index_a       <= '0;
							out_q.index_b       <= '0;
							out_q.index_c       <= '0;
							out_q.new_vertex    <= 1'b0;
							out_q.from_animated <= 1'b0;
							out_q.table_full    <= 1'b0;
							out_q.last          <= 1'b1;
							state_q             <= ST_IDLE;
						end
						OP_ANIM: begin
							if (anim_cnt_q < MAX_CNT) begin
								res_idx_q  <= anim_cnt_q[IDX_W-1:0];
								res_nv_q   <= 1'b1;
								res_full_q <= 1'b0;
								anim_cnt_q <= anim_cnt_q + CNT_W'(1);
							end else begin
								res_idx_q  <= '0;
								res_nv_q   <= 1'b0;
								res_full_q <= 1'b1;
							end
							state_q <= ST_REPORT;
						end
						default: begin
							ptr_q   <= '0;
							state_q <= ST_SCAN;
						end
					endcase
				end
				ST_SCAN: begin
					if (hit) begin
						res_idx_q  <= rd_idx_q;
						res_nv_q   <= 1'b0;
						res_full_q <= 1'b0;
						state_q    <= ST_REPORT;
					end else if (scan_end) begin
						if (wr_en) begin
							res_idx_q    <= normal_cnt_q[IDX_W-1:0];
							res_nv_q     <= 1'b1;
							res_full_q   <= 1'b0;
							normal_cnt_q <= normal_cnt_q + CNT_W'(1);
						end else begin
							res_idx_q  <= '0;
							res_nv_q   <= 1'b0;
							res_full_q <= 1'b1;
						end
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					out_q.kind          <= KIND_REPORT;
					out_q.index_a       <= out_idx(res_idx_q);
					out_q.index_b       <= '0;
					out_q.index_c       <= '0;
					out_q.new_vertex    <= res_nv_q;
					out_q.from_animated <= item_q.animated;
					out_q.table_full    <= res_full_q;
					out_q.last          <= res_full_q || (fan_pos_q != FAN_RUN);
					state_q <= (!res_full_q && (fan_pos_q == FAN_RUN)) ? ST_FRONT : ST_IDLE;
					if (!res_full_q) begin
						unique case (fan_pos_q)
							FAN_EMPTY: begin
								fan_start_q <= res_idx_q;
								fan_pos_q   <= FAN_START;
							end
							FAN_START: begin
								fan_prev_q <= res_idx_q;
								fan_pos_q  <= FAN_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FRONT: begin
					out_q.kind          <= KIND_FRONT;
					out_q.index_a       <= out_idx(fan_start_q);
					out_q.index_b       <= out_idx(fan_prev_q);
					out_q.index_c       <= out_idx(res_idx_q);
					out_q.new_vertex    <= 1'b0;
					out_q.from_animated <= item_q.animated;
					out_q.table_full    <= 1'b0;
					out_q.last          <= !item_q.two_sided;
					if (item_q.two_sided) begin
						state_q <= ST_BACK;
					end else begin
						fan_prev_q <= res_idx_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_BACK: begin
					out_q.kind          <= KIND_BACK;
					out_q.index_a       <= out_idx(fan_start_q);
					out_q.index_b       <= out_idx(res_idx_q);
					out_q.index_c       <= out_idx(fan_prev_q);
					out_q.new_vertex    <= 1'b0;
					out_q.from_animated <= item_q.animated;
					out_q.table_full    <= 1'b0;
					out_q.last          <= 1'b1;
					fan_prev_q          <= res_idx_q;
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FTVD_NEVER(a_cnt_range, clk, arst_n, (normal_cnt_q > MAX_CNT) || (anim_cnt_q > MAX_CNT))
	`FTVD_NEVER(a_ptr_range, clk, arst_n, in_scan && (ptr_q > normal_cnt_q))
	`FTVD_ASSERT(a_beat_chain, clk, arst_n, (out_vld_q && !out_q.last) |=> out_vld_q)
	`FTVD_ASSERT(a_clear_cnt, clk, arst_n, (out_vld_q && (out_q.kind == KIND_CLEAR)) |-> ((normal_cnt_q == '0) && (anim_cnt_q == '0)))

endmodule

[rtl/core/fan_triangulator_vertex_dedup_core.sv]
`timescale 1ns / 1ps

// Fan triangulator with vertex deduplication. An item is taken when start is high and
// busy is low; up to two items wait in a queue while the previous one is worked on.
// Results come out one beat per cycle on result, marked by result_valid for exactly one
// cycle each, and cannot be held off. A normal vertex scans the stored keys at one entry
// per cycle through the single read port of the key memory. Each item gives 1 to 3
// results.

module fan_triangulator_vertex_dedup_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ftvd_pkg::in_t  item,
	output logic           result_valid,
	output ftvd_pkg::out_t result
);
	import ftvd_pkg::*;

	logic  q_vld;
	qent_t q_head;
	logic  pop;

	ftvd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.q_vld  (q_vld),
		.q_head (q_head),
		.pop    (pop)
	);

	ftvd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_vld        (q_vld),
		.q_head       (q_head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[bench/ftvd_fan_checker.sv]
`timescale 1ns / 1ps

module ftvd_fan_checker
	import ftvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_t  item,
	input  logic result_valid,
	input  out_t result,
	output int   mismatch_count,
	output int   awaited_count
);

	key_t                 vertex_keys [MAX_VERTICES];
	int                   normal_used;
	int                   anim_used;
	logic [OUT_IDX_W-1:0] fan_root;
	logic [OUT_IDX_W-1:0] fan_prev;
	logic [1:0]           fan_state;
	out_t                 awaited_beats [$];

	// NaN never matches; signed zeros are equal
	function automatic logic float_same(input logic [31:0] a, input logic [31:0] b);
		if ((&a[30:23] && |a[22:0]) || (&b[30:23] && |b[22:0])) begin
			return 1'b0;
		end
		return (a == b) || (a[30:0] == 31'd0 && b[30:0] == 31'd0);
	endfunction

	function automatic logic key_hit(input key_t s, input in_t it);
		return float_same(s.pos_x, it.pos_x) && float_same(s.pos_y, it.pos_y) &&
			float_same(s.pos_z, it.pos_z) && float_same(s.tex_u, it.tex_u) &&
			float_same(s.tex_v, it.tex_v);
	endfunction

	task automatic clear_mesh();
		normal_used = 0;
		anim_used   = 0;
		fan_root    = '0;
		fan_prev    = '0;
		fan_state   = FAN_EMPTY;
	endtask

	task automatic push_beat(input logic [1:0] kind, input logic [OUT_IDX_W-1:0] a,
			input logic [OUT_IDX_W-1:0] b, input logic [OUT_IDX_W-1:0] c,
			input logic nv, input logic anim, input logic full, input logic fin);
		out_t r;
		r.kind          = kind;
		r.index_a       = a;
		r.index_b       = b;
		r.index_c       = c;
		r.new_vertex    = nv;
		r.from_animated = anim;
		r.table_full    = full;
		r.last          = fin;
		awaited_beats.push_back(r);
	endtask

	task automatic predict_fan_beats(input in_t it);
		logic [OUT_IDX_W-1:0] idx;
		logic                 nv;
		logic                 full;
		logic                 emit;
		int                   hit;
		if (it.command) begin
			clear_mesh();
			push_beat(KIND_CLEAR, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
		end else begin
			if (it.first_vertex) begin
				fan_state = FAN_EMPTY;
			end
			idx  = '0;
			nv   = 1'b0;
			full = 1'b0;
			hit  = -1;
			if (it.animated) begin
				if (anim_used < MAX_VERTICES) begin
					idx = anim_used[OUT_IDX_W-1:0];
					anim_used++;
					nv = 1'b1;
				end else begin
					full = 1'b1;
				end
			end else begin
				for (int i = 0; i < normal_used && hit < 0; i++) begin
					if (key_hit(vertex_keys[i], it)) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					idx = hit[OUT_IDX_W-1:0];
				end else if (normal_used < MAX_VERTICES) begin
					idx = normal_used[OUT_IDX_W-1:0];
					vertex_keys[normal_used] = '{pos_x: it.pos_x, pos_y: it.pos_y,
						pos_z: it.pos_z, tex_u: it.tex_u, tex_v: it.tex_v};
					normal_used++;
					nv = 1'b1;
				end else begin
					full = 1'b1;
				end
			end
			emit = !full && fan_state == FAN_RUN;
			push_beat(KIND_REPORT, idx, '0, '0, nv, it.animated, full, !emit);
			if (!full) begin
				if (fan_state == FAN_EMPTY) begin
					fan_root  = idx;
					fan_state = FAN_START;
				end else if (fan_state == FAN_START) begin
					fan_prev  = idx;
					fan_state = FAN_RUN;
				end else begin
					push_beat(KIND_FRONT, fan_root, fan_prev, idx, 1'b0, it.animated, 1'b0,
						!it.two_sided);
					if (it.two_sided) begin
						push_beat(KIND_BACK, fan_root, idx, fan_prev, 1'b0, it.animated, 1'b0,
							1'b1);
					end
					fan_prev = idx;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		out_t want;
		if (!arst_n) begin
			clear_mesh();
			awaited_beats.delete();
			mismatch_count = 0;
		end else begin
			if (result_valid) begin
				if (awaited_beats.size() == 0) begin
					$error("unexpected result beat: kind %0d, index_a %0d",
						result.kind, result.index_a);
					mismatch_count++;
				end else begin
					want = awaited_beats.pop_front();
					check_field("kind", want.kind, result.kind);
					check_field("index_a", want.index_a, result.index_a);
					check_field("index_b", want.index_b, result.index_b);
					check_field("index_c", want.index_c, result.index_c);
					check_field("new_vertex", want.new_vertex, result.new_vertex);
					check_field("from_animated", want.from_animated, result.from_animated);
					check_field("table_full", want.table_full, result.table_full);
					check_field("last", want.last, result.last);
				end
			end
			if (start && !busy) begin
				predict_fan_beats(item);
			end
		end
		awaited_count = awaited_beats.size();
	end

endmodule

[bench/fan_triangulator_vertex_dedup_core_tb.sv]
`timescale 1ns / 1ps

module fan_triangulator_vertex_dedup_core_tb;
	import ftvd_pkg::*;

	localparam int CYCLE_LIMIT  = 4000000;
	localparam int RANDOM_ITEMS = 330;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  item;
	logic result_valid;
	out_t result;
	int   mismatch_count;
	int   awaited_count;
	int   cycle_count;
	int   items_sent;
	logic no_gaps;
	key_t recent_keys [$];

	fan_triangulator_vertex_dedup_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	ftvd_fan_checker fan_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.item           (item),
		.result_valid   (result_valid),
		.result         (result),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [31:0] rand_float();
		case ($urandom_range(0, 19))
			0:       return {1'($urandom), 8'hFF, 22'($urandom), 1'b1};
			1:       return {1'($urandom), 8'hFF, 23'd0};
			2, 3:    return 32'h0000_0000;
			4, 5:    return 32'h8000_0000;
			6, 7, 8: return 32'h3F80_0000 + $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] flip_zero_sign(input logic [31:0] c);
		return (c[30:0] == 31'd0) ? {1'($urandom), 31'd0} : c;
	endfunction

	function automatic in_t vertex_beat(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] tu, input logic [31:0] tv,
			input logic anim, input logic dbl, input logic first_v);
		in_t v;
		v.command      = 1'b0;
		v.pos_x        = px;
		v.pos_y        = py;
		v.pos_z        = pz;
		v.tex_u        = tu;
		v.tex_v        = tv;
		v.animated     = anim;
		v.two_sided    = dbl;
		v.first_vertex = first_v;
		return v;
	endfunction

	// mostly fresh keys, with repeats of recent ones to hit the dedup path
	function automatic in_t make_vertex(input logic anim, input logic dbl, input logic first_v);
		key_t k;
		if (recent_keys.size() > 0 && $urandom_range(0, 9) < 4) begin
			k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			k.pos_x = flip_zero_sign(k.pos_x);
			k.pos_y = flip_zero_sign(k.pos_y);
			k.pos_z = flip_zero_sign(k.pos_z);
			k.tex_u = flip_zero_sign(k.tex_u);
			k.tex_v = flip_zero_sign(k.tex_v);
		end else begin
			k = '{rand_float(), rand_float(), rand_float(), rand_float(), rand_float()};
			recent_keys.push_back(k);
			if (recent_keys.size() > 48) begin
				recent_keys.delete(0);
			end
		end
		return vertex_beat(k.pos_x, k.pos_y, k.pos_z, k.tex_u, k.tex_v, anim, dbl, first_v);
	endfunction

	function automatic in_t make_noise();
		return vertex_beat($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			1'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	task automatic send_item(input in_t it);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic send_clear();
		in_t v;
		v = make_noise();
		v.command = 1'b1;
		recent_keys.delete();
		send_item(v);
	endtask

	task automatic send_polygon(input logic anim, input logic dbl, input int len,
			input logic mixed, input logic headless);
		logic a;
		for (int i = 0; i < len; i++) begin
			a = mixed ? 1'($urandom) : anim;
			send_item(make_vertex(a, dbl, (i == 0) && !headless));
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (awaited_count != 0) @(negedge clk);
	endtask

	initial begin
		int   stop_at;
		int   pick;
		in_t  v;
		start      = 1'b0;
		item       = '0;
		arst_n     = 1'b0;
		no_gaps    = 1'b0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fan opened without a first flag; signed zeros dedup
		send_item(vertex_beat(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0));
		send_item(vertex_beat(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0,
			1'b0, 1'b0, 1'b0));
		send_item(vertex_beat(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0,
			32'h3F80_0000, 1'b0, 1'b1, 1'b0));
		// NaN keys are appended every time
		send_item(vertex_beat(32'h7FC0_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0));
		send_item(vertex_beat(32'h7FC0_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0));
		send_item(vertex_beat('1, '1, '1, '1, '1, 1'b0, 1'b1, 1'b1));
		send_item(vertex_beat(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001,
			32'h8000_0001, 1'b0, 1'b0, 1'b0));
		send_item(vertex_beat(32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001,
			32'h8000_0001, 1'b0, 1'b1, 1'b0));
		send_item(vertex_beat(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0,
			32'h3F80_0000, 1'b0, 1'b1, 1'b0));
		for (int i = 0; i < 5; i++) begin
			send_item(vertex_beat(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0,
				32'h3F80_0000, 1'b1, 1'b1, i == 0));
		end
		// animated flag toggling inside one fan
		send_item(vertex_beat(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0,
			32'h3F80_0000, 1'b0, 1'b1, 1'b0));
		send_item(vertex_beat(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0));
		v = vertex_beat('1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
		v.command = 1'b1;
		send_item(v);
		send_item(vertex_beat(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h0,
			32'h3F80_0000, 1'b0, 1'b0, 1'b0));
		send_item(vertex_beat(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0));
		send_item(vertex_beat(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0));
		drain();

		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0) begin
				no_gaps = !no_gaps;
			end
			if (pick < 4) begin
				if ($urandom_range(0, 1) == 1) begin
					drain();
				end
				send_clear();
			end else if (pick < 16) begin
				send_item(make_noise());
			end else begin
				send_polygon($urandom_range(0, 4) == 0, 1'($urandom), $urandom_range(3, 7),
					$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
			end
		end
		no_gaps = 1'b0;

		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ftvd_pkg.sv
rtl/core/ftvd_front.sv
rtl/core/ftvd_back.sv
rtl/core/fan_triangulator_vertex_dedup_core.sv
bench/ftvd_fan_checker.sv
bench/fan_triangulator_vertex_dedup_core_tb.sv
